// ----- rtl/core/periodic_task_priority_queue_assert.svh -----
// Assertion macros used by the checker of the periodic task queue.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef PERIODIC_TASK_PRIORITY_QUEUE_ASSERT_SVH
`define PERIODIC_TASK_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PTPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Property of the cycle that follows a reset cycle.
`define PTPQ_ASSERT_RST(label, cons, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ptpq_pkg.sv -----
// Package of the periodic task queue: sizes, entry layout, status codes
// and the command and status structs between controller and datapath.
// Depends on nothing.
package ptpq_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(DEPTH + 1);

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 2;
    localparam int CNT_LSB   = 80;
    localparam int CNT_W     = 5;
    localparam int M_PAD_W   = M_TDATA_W - CNT_LSB - CNT_W;

    typedef struct packed {
        logic [31:0] due;
        logic [31:0] per;
        logic [7:0]  pri;
        logic [7:0]  id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic capture;
        logic decide;
        logic head;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic pop;
        logic done;
    } t_stat;

endpackage

// ----- rtl/core/ptpq_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module ptpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ptpq_ctrl.sv -----
// Controller of the periodic task queue: sequences capture, decision,
// head read, table walk and result transfer. Depends on ptpq_pkg.
module ptpq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  ptpq_pkg::t_stat i_stat,
    output ptpq_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_HEAD,
        S_WALK,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.decide   = (r_state == S_DECIDE);
        o_cmd.head     = (r_state == S_HEAD);
        o_cmd.step     = (r_state == S_WALK);
        o_cmd.load_out = (r_state == S_RESP) && (!r_out_valid || i_m_tready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.err) begin
                    n_state = S_RESP;
                end else if (i_stat.pop) begin
                    n_state = S_HEAD;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_HEAD: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (i_stat.done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (o_cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

// ----- rtl/core/ptpq_dpath.sv -----
// Datapath of the periodic task queue: request registers, table RAM,
// ordered insertion walk, occupancy and result registers.
// Depends on ptpq_pkg and ptpq_ram.
module ptpq_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptpq_pkg::t_cmd    i_cmd,
    input  logic              i_mode,
    input  logic [31:0]       i_now_seconds,
    input  logic [7:0]        i_task_id,
    input  logic [31:0]       i_period,
    input  logic [7:0]        i_task_priority,
    output ptpq_pkg::t_stat   o_stat,
    output ptpq_pkg::t_status o_status,
    output logic [7:0]        o_popped_task,
    output logic [7:0]        o_popped_priority,
    output logic [31:0]       o_popped_period,
    output logic [31:0]       o_next_due,
    output logic [4:0]        o_entry_count
);

    localparam int AW = ptpq_pkg::AW;
    localparam int IW = ptpq_pkg::IW;

    logic              r_mode;
    logic [31:0]       r_now;
    ptpq_pkg::t_entry  r_n;
    ptpq_pkg::t_entry  r_carry;
    logic [IW-1:0]     r_i;
    logic              r_placed;
    logic [IW-1:0]     r_occ;
    ptpq_pkg::t_status r_status;

    ptpq_pkg::t_status r_o_status;
    logic [7:0]        r_o_task;
    logic [7:0]        r_o_prio;
    logic [31:0]       r_o_per;
    logic [31:0]       r_o_due;
    logic [4:0]        r_o_count;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    ptpq_pkg::t_entry         ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [ptpq_pkg::ENTRY_W-1:0] ram_rdata;
    ptpq_pkg::t_entry         rd_entry;

    logic [IW:0]       src_idx;
    logic [IW:0]       next_addr;
    logic              src_valid;
    logic              new_first;
    logic              place_now;
    logic              walk_done;
    ptpq_pkg::t_status err_code;

    assign rd_entry  = ptpq_pkg::t_entry'(ram_rdata);
    assign src_idx   = {1'b0, r_i} + (IW + 1)'(r_mode);
    assign next_addr = src_idx + (IW + 1)'(1);
    assign src_valid = src_idx < {1'b0, r_occ};
    assign new_first = (r_n.due < rd_entry.due) ||
                       ((r_n.due == rd_entry.due) && (r_n.pri > rd_entry.pri));
    assign place_now = !r_placed && (!src_valid || new_first);
    assign walk_done = !src_valid || (r_mode && place_now);

    always_comb begin
        err_code = ptpq_pkg::ST_OK;
        if (!r_mode && (r_occ == IW'(ptpq_pkg::DEPTH))) begin
            err_code = ptpq_pkg::ST_FULL;
        end else if (r_mode && (r_occ == '0)) begin
            err_code = ptpq_pkg::ST_EMPTY;
        end
    end

    always_comb begin
        o_stat      = '0;
        o_stat.err  = (err_code != ptpq_pkg::ST_OK);
        o_stat.pop  = r_mode;
        o_stat.done = walk_done;
    end

    always_comb begin
        ram_re    = i_cmd.decide || i_cmd.head || i_cmd.step;
        ram_raddr = next_addr[AW-1:0];
        if (i_cmd.decide) begin
            ram_raddr = '0;
        end else if (i_cmd.head) begin
            ram_raddr = AW'(1);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_i[AW-1:0];
        ram_wdata = r_carry;
        if (i_cmd.step) begin
            if (place_now) begin
                ram_we    = 1'b1;
                ram_wdata = r_n;
            end else if (r_placed) begin
                ram_we    = 1'b1;
                ram_wdata = r_carry;
            end else if (r_mode) begin
                ram_we    = 1'b1;
                ram_wdata = rd_entry;
            end
        end
    end

    ptpq_ram #(
        .WIDTH (ptpq_pkg::ENTRY_W),
        .DEPTH (ptpq_pkg::DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.step && walk_done && !r_mode) begin
            r_occ <= r_occ + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_now   <= i_now_seconds;
            r_n.due <= i_now_seconds + i_period;
            r_n.per <= i_period;
            r_n.pri <= i_task_priority;
            r_n.id  <= i_task_id;
        end
        if (i_cmd.decide) begin
            r_status <= err_code;
            r_i      <= '0;
            r_placed <= 1'b0;
        end
        if (i_cmd.head) begin
            r_n.due <= r_now + rd_entry.per;
            r_n.per <= rd_entry.per;
            r_n.pri <= rd_entry.pri;
            r_n.id  <= rd_entry.id;
        end
        if (i_cmd.step) begin
            r_i     <= r_i + IW'(1);
            r_carry <= rd_entry;
            if (place_now) begin
                r_placed <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_count  <= 5'(r_occ);
            if ((r_status == ptpq_pkg::ST_OK) && r_mode) begin
                r_o_task <= r_n.id;
                r_o_prio <= r_n.pri;
                r_o_per  <= r_n.per;
            end else begin
                r_o_task <= '0;
                r_o_prio <= '0;
                r_o_per  <= '0;
            end
            if (r_status == ptpq_pkg::ST_OK) begin
                r_o_due <= r_n.due;
            end else begin
                r_o_due <= '0;
            end
        end
    end

    assign o_status          = r_o_status;
    assign o_popped_task     = r_o_task;
    assign o_popped_priority = r_o_prio;
    assign o_popped_period   = r_o_per;
    assign o_next_due        = r_o_due;
    assign o_entry_count     = r_o_count;

endmodule

// ----- rtl/core/periodic_task_priority_queue.sv -----
// Periodic task queue sorted by due time, priority and arrival order.
// A rejected request goes from the decision straight to the result; a push walks the table,
// and a pop reads the head first and then walks the table; a stall on the output delays the result.
// The walk handles one table entry per cycle; the next input transfer is taken in the cycle
// after the result is loaded, even while the result waits on the output.
// Synchronous active-low reset empties the table at once; contents are not cleared.
module periodic_task_priority_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // now_seconds, task_id, period, task_priority
    input  logic [ptpq_pkg::S_TDATA_W-1:0] i_s_tdata,
    // mode
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // popped_task, popped_priority, popped_period, next_due, entry_count, zero pad
    output logic [ptpq_pkg::M_TDATA_W-1:0] o_m_tdata,
    // status
    output logic [ptpq_pkg::M_TUSER_W-1:0] o_m_tuser
);

    ptpq_pkg::t_cmd    cmd;
    ptpq_pkg::t_stat   stat;
    ptpq_pkg::t_status status;
    logic [7:0]        popped_task;
    logic [7:0]        popped_priority;
    logic [31:0]       popped_period;
    logic [31:0]       next_due;
    logic [4:0]        entry_count;

    ptpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptpq_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_mode            (i_s_tuser),
        .i_now_seconds     (i_s_tdata[31:0]),
        .i_task_id         (i_s_tdata[39:32]),
        .i_period          (i_s_tdata[71:40]),
        .i_task_priority   (i_s_tdata[79:72]),
        .o_stat            (stat),
        .o_status          (status),
        .o_popped_task     (popped_task),
        .o_popped_priority (popped_priority),
        .o_popped_period   (popped_period),
        .o_next_due        (next_due),
        .o_entry_count     (entry_count)
    );

    assign o_m_tdata = {{ptpq_pkg::M_PAD_W{1'b0}}, entry_count, next_due,
                        popped_period, popped_priority, popped_task};
    assign o_m_tuser = ptpq_pkg::M_TUSER_W'(status);

endmodule

// ----- rtl/core/ptpq_checker.sv -----
// Checker on the result port of the periodic task queue, bound to the top level.
// Depends on ptpq_pkg and periodic_task_priority_queue_assert.svh.
`include "periodic_task_priority_queue_assert.svh"

module ptpq_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [ptpq_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic [ptpq_pkg::M_TUSER_W-1:0] i_m_tuser
);

    `PTPQ_ASSERT_IMP(a_empty_zero, i_m_tvalid && (i_m_tuser == ptpq_pkg::ST_EMPTY), i_m_tdata == '0, "empty result carries data")
    `PTPQ_ASSERT_IMP(a_full_no_task, i_m_tvalid && (i_m_tuser == ptpq_pkg::ST_FULL), i_m_tdata[ptpq_pkg::CNT_LSB-1:0] == '0, "full result carries task data")
    `PTPQ_ASSERT_IMP(a_status_code, i_m_tvalid, (i_m_tuser == ptpq_pkg::ST_OK) || (i_m_tuser == ptpq_pkg::ST_FULL) || (i_m_tuser == ptpq_pkg::ST_EMPTY), "undefined status code")
    `PTPQ_ASSERT_NXT(a_hold, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser), "stalled result changed")
    `PTPQ_ASSERT_RST(a_reset_idle, !i_m_tvalid, "result valid after reset")

endmodule

bind periodic_task_priority_queue ptpq_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);

// ----- sim/tb_periodic_task_priority_queue.sv -----
// Self-checking testbench for periodic_task_priority_queue: a directed table, then random
// push and pop traffic under varying backpressure, checked against a due-time-ordered shadow table.
// Depends on ptpq_pkg and the periodic_task_priority_queue RTL.
module tb_periodic_task_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;
    import ptpq_pkg::*;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] now;
        logic [7:0]  id;
        logic [31:0] per;
        logic [7:0]  pri;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [7:0]  task_id;
        logic [7:0]  prio;
        logic [31:0] per;
        logic [31:0] next_due;
        logic [4:0]  count;
    } t_res;

    typedef struct packed {
        logic known;
        t_req req;
        t_res res;
    } t_row;

    localparam int   N_RANDOM    = 700;
    localparam int   N_DIRECTED  = 25;
    localparam int   STALL_LIMIT = 5000;
    localparam int   HOLD_CYCLES = 400;
    localparam int   TAIL_CYCLES = 40;
    localparam t_res NO_RES      = '0;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 i_s_tuser  = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;

    periodic_task_priority_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    t_entry sched_tbl [DEPTH];
    int     sched_cnt   = 0;
    t_res   due_q [$];
    t_row   offer_q [$];
    t_row   dir_tbl [N_DIRECTED];
    int     n_err       = 0;
    int     quiet       = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    int     hold_asked  = 0;

    function automatic void sched_insert(input t_entry e);
        int   pos;
        logic stop;
        pos  = 0;
        stop = 1'b0;
        while (!stop && pos < sched_cnt) begin
            if (e.due < sched_tbl[pos].due ||
                (e.due == sched_tbl[pos].due && e.pri > sched_tbl[pos].pri))
                stop = 1'b1;
            else
                pos++;
        end
        for (int k = sched_cnt; k > pos; k--)
            sched_tbl[k] = sched_tbl[k - 1];
        sched_tbl[pos] = e;
        sched_cnt++;
    endfunction

    function automatic t_res sched_step(input t_req rq);
        t_res   r;
        t_entry e;
        r        = NO_RES;
        r.status = ST_OK;
        if (rq.op == OP_PUSH) begin
            if (sched_cnt >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                e.due = rq.now + rq.per;
                e.per = rq.per;
                e.pri = rq.pri;
                e.id  = rq.id;
                sched_insert(e);
                r.next_due = e.due;
            end
        end else if (sched_cnt == 0) begin
            r.status = ST_EMPTY;
        end else begin
            e = sched_tbl[0];
            for (int k = 1; k < sched_cnt; k++)
                sched_tbl[k - 1] = sched_tbl[k];
            sched_cnt--;
            r.task_id = e.id;
            r.prio    = e.pri;
            r.per     = e.per;
            e.due     = rq.now + e.per;
            sched_insert(e);
            r.next_due = e.due;
        end
        r.count = 5'(sched_cnt);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            n_err++;
            if (n_err <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_row row;
        t_res want;
        t_res got;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.status   = t_status'(o_m_tuser);
                got.task_id  = o_m_tdata[7:0];
                got.prio     = o_m_tdata[15:8];
                got.per      = o_m_tdata[47:16];
                got.next_due = o_m_tdata[79:48];
                got.count    = o_m_tdata[CNT_LSB +: CNT_W];
                if (due_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("result transfer with nothing outstanding: %h", got);
                end else begin
                    want = due_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("popped_task", want.task_id, got.task_id);
                    check_field("popped_priority", want.prio, got.prio);
                    check_field("popped_period", want.per, got.per);
                    check_field("next_due", want.next_due, got.next_due);
                    check_field("entry_count", want.count, got.count);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                row  = offer_q.pop_front();
                want = sched_step(row.req);
                due_q.push_back(row.known ? row.res : want);
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic offer(input t_row row);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        offer_q.push_back(row);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {row.req.pri, row.req.per, row.req.id, row.req.now};
        i_s_tuser  <= row.req.op;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Stops offering and waits until every outstanding result has been transferred.
    task automatic await_drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (due_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(3))
            0:       return 32'($urandom_range(15));
            1:       return 32'hFFFF_FFFF - 32'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_row row;
        int   push_pct;
        int   run_left;
        dir_tbl = '{
            {1'b1, OP_POP,  32'h0000_0000, 8'h00, 32'h0000_0000, 8'h00,
                   ST_EMPTY, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 5'd0},
            {1'b1, OP_PUSH, 32'h0000_0000, 8'hFF, 32'hFFFF_FFFF, 8'hFF,
                   ST_OK, 8'h00, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 5'd1},
            {1'b1, OP_POP,  32'h0000_0001, 8'h00, 32'h0000_0000, 8'h00,
                   ST_OK, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000, 5'd1},
            {1'b0, OP_PUSH, 32'h0000_0000, 8'h00, 32'h0000_0000, 8'h00, NO_RES},
            {1'b0, OP_PUSH, 32'h0000_0000, 8'h01, 32'h0000_0000, 8'h80, NO_RES},
            {1'b0, OP_PUSH, 32'h0000_0000, 8'h02, 32'h0000_0000, 8'h80, NO_RES},
            {1'b0, OP_PUSH, 32'hFFFF_FFF0, 8'h03, 32'h0000_0020, 8'h01, NO_RES},
            {1'b0, OP_PUSH, 32'h0000_0010, 8'h04, 32'h0000_0000, 8'h01, NO_RES},
            {1'b0, OP_PUSH, 32'hAAAA_AAAA, 8'hAA, 32'h5555_5555, 8'h55, NO_RES},
            {1'b0, OP_PUSH, 32'h5555_5555, 8'h55, 32'hAAAA_AAAA, 8'hAA, NO_RES},
            {1'b0, OP_PUSH, 32'hFFFF_FFFF, 8'h7F, 32'hFFFF_FFFF, 8'h7F, NO_RES},
            {1'b0, OP_PUSH, 32'h1234_5678, 8'h10, 32'h0000_0000, 8'h10, NO_RES},
            {1'b0, OP_PUSH, 32'h0000_0000, 8'h11, 32'h1234_5678, 8'h10, NO_RES},
            {1'b0, OP_PUSH, 32'h8000_0000, 8'h20, 32'h8000_0000, 8'hFF, NO_RES},
            {1'b0, OP_PUSH, 32'h0000_0001, 8'h21, 32'h0000_0001, 8'h03, NO_RES},
            {1'b0, OP_PUSH, 32'h7FFF_FFFF, 8'h22, 32'h0000_0001, 8'hFE, NO_RES},
            {1'b0, OP_PUSH, 32'h0000_0000, 8'h23, 32'h0000_0001, 8'h00, NO_RES},
            {1'b0, OP_PUSH, 32'h0000_0000, 8'h24, 32'h0000_0002, 8'h00, NO_RES},
            {1'b1, OP_PUSH, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF,
                   ST_FULL, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 5'd16},
            {1'b0, OP_POP,  32'h0000_0000, 8'hAA, 32'h5555_5555, 8'h55, NO_RES},
            {1'b0, OP_POP,  32'h0000_0000, 8'h55, 32'hAAAA_AAAA, 8'hAA, NO_RES},
            {1'b0, OP_POP,  32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, NO_RES},
            {1'b0, OP_POP,  32'h0000_0010, 8'h00, 32'h0000_0000, 8'h00, NO_RES},
            {1'b0, OP_POP,  32'h8000_0000, 8'h01, 32'h0000_0001, 8'h01, NO_RES},
            {1'b0, OP_POP,  32'h7FFF_FFFF, 8'h02, 32'h0000_0002, 8'h02, NO_RES}
        };
        tx_idle_pct = 32;
        rx_idle_pct = 48;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i])
            offer(dir_tbl[i]);
        await_drain();

        push_pct = 30;
        run_left = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                await_drain();
                tx_idle_pct = 48;
                rx_idle_pct = 32;
            end else if (n == 2 * N_RANDOM / 3) begin
                await_drain();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_asked++;
            end
            // Alternate filling and draining runs so the table reaches both full and empty.
            if (run_left == 0) begin
                push_pct = (push_pct == 70) ? 30 : 70;
                run_left = $urandom_range(60, 10);
            end
            run_left--;
            row.known   = 1'b0;
            row.res     = NO_RES;
            row.req.op  = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
            row.req.now = pick_time();
            row.req.per = pick_time();
            row.req.id  = 8'($urandom);
            row.req.pri = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
            offer(row);
        end

        await_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_err == 0 && due_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ptpq_pkg.sv
rtl/core/ptpq_ram.sv
rtl/core/ptpq_ctrl.sv
rtl/core/ptpq_dpath.sv
rtl/core/periodic_task_priority_queue.sv
rtl/core/ptpq_checker.sv
sim/tb_periodic_task_priority_queue.sv
